// ===== rtl/core/strict_local_max_3x3_detector_top_assert.svh =====
// ----------------------------------------------------------------------------
// strict_local_max_3x3_detector_top_assert.svh
// assertion macros used by the checker file of the detector
// ----------------------------------------------------------------------------
`ifndef STRICT_LOCAL_MAX_3X3_DETECTOR_TOP_ASSERT_SVH
`define STRICT_LOCAL_MAX_3X3_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SLM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg
// types, constants and helper functions of the 3x3 strict local max detector
// ----------------------------------------------------------------------------
package slm_pkg;

    // field widths
    localparam int PIX_W       = 10;
    localparam int DIM_W       = 9;
    localparam int COUNT_W     = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int DIM_MAX     = (1 << DIM_W) - 1;
    localparam int MAX_HEIGHT  = 256;

    // front to back job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [DIM_W-1:0]   DIM_RESET = DIM_W'(200);

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [DIM_W-1:0] dim_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // input item kinds
    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t kind;
        pix_t  pixel_value;
    } item_t;

    typedef struct packed {
        dim_t               row_index;
        dim_t               col_index;
        logic               is_peak;
        logic [COUNT_W-1:0] peak_total;
        logic               frame_done;
        logic               end_of_run;
    } result_t;

    // one window column, top row to bottom row
    typedef struct packed {
        pix_t up;
        pix_t mid;
        pix_t low;
    } col_t;

    // window, index 0 is the left column
    typedef col_t [2:0] win_t;

    // classified work handed from front to back
    typedef struct packed {
        kind_t kind;
        dim_t  row;
        dim_t  col;
        logic  col_first;
        logic  col_last;
        logic  row_ge2;
        logic  seed;
        logic  done;
        col_t  data;
    } job_t;

    // out-of-range dimension handling: zero acts as one, large values cap
    function automatic dim_t clamp_dim(dim_t v, dim_t cap);
        if (v == '0)
            return DIM_W'(1);
        if (v > cap)
            return cap;
        return v;
    endfunction

    // centre strictly above all eight neighbors
    function automatic logic slm_is_peak(win_t w);
        pix_t c;
        c = w[1].mid;
        return (c > w[0].up) && (c > w[0].mid) && (c > w[0].low)
            && (c > w[1].up) && (c > w[1].low)
            && (c > w[2].up) && (c > w[2].mid) && (c > w[2].low);
    endfunction

endpackage

// ===== rtl/core/strict_local_max_3x3_detector_top.sv =====
// ----------------------------------------------------------------------------
// strict_local_max_3x3_detector_top
// path: an item's decision passes the issue stage, the job queue and the result register
// throughput: one item per cycle while the job queue has room; a row-end pixel giving two decisions holds
//   the single decision unit and result register for both of them
// reset: position counters, window, peak count, queue and result are cleared;
//   line store contents are left as they are, with no clearing pass
// ----------------------------------------------------------------------------
module strict_local_max_3x3_detector_top #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  slm_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output slm_pkg::result_t                 result,
    input  logic                             cfg_write,
    input  logic [slm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slm_pkg::DIM_W-1:0]        cfg_data
);
    import slm_pkg::*;

    logic push, pop, head_valid, restart;
    job_t push_job, head_job;
    logic [QCOUNT_W-1:0] q_count;

    // front: position tracking and line store
    slm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_count    (q_count),
        .push       (push),
        .push_job   (push_job),
        .restart    (restart)
    );

    // job queue
    slm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .count      (q_count)
    );

    // back: window and decisions
    slm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .restart      (restart),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== rtl/core/slm_front.sv =====
// ----------------------------------------------------------------------------
// slm_front
// accepts items, tracks the raster position, owns the line store and
// hands classified jobs with their neighborhood column to the queue
// ----------------------------------------------------------------------------
module slm_front #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  slm_pkg::item_t                   item,
    input  logic                             cfg_write,
    input  logic [slm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slm_pkg::DIM_W-1:0]        cfg_data,
    input  logic [slm_pkg::QCOUNT_W-1:0]     q_count,
    output logic                             push,
    output slm_pkg::job_t                    push_job,
    output logic                             restart
);
    import slm_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam dim_t WIDTH_CAP  = (MAX_WIDTH > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_WIDTH);
    localparam dim_t HEIGHT_CAP = DIM_W'(MAX_HEIGHT);

    typedef struct packed {
        pix_t up;
        pix_t mid;
    } line_word_t;

    // configuration and raster position
    dim_t width_reg, width_next;
    dim_t height_reg, height_next;
    dim_t row_reg, row_next;
    dim_t col_reg, col_next;
    dim_t pend_reg, pend_next;
    logic flushing_reg, flushing_next;

    // issue stage
    logic       f1_valid_reg, f1_valid_next;
    job_t       f1_job_reg, f1_job_next;
    logic [AW-1:0] f1_addr_reg;
    logic       f1_hit_reg;
    logic       f1_use_up_reg, f1_use_up_next;
    logic       f1_use_mid_reg, f1_use_mid_next;

    // line store
    line_word_t line_mem [MAX_WIDTH];
    line_word_t rd_word_reg;
    line_word_t wr_word_reg;
    line_word_t eff_word;
    line_word_t wr_word;

    dim_t w_eff, h_eff, c_eff, r_eff, p_eff;
    logic is_pix, accept, take_pix, take_flush, take_any, hit, f1_write;
    logic [AW-1:0] raddr;
    logic [QCOUNT_W:0] occupancy;

    // credit check against the queue
    assign occupancy  = {1'b0, q_count} + (QCOUNT_W + 1)'(f1_valid_reg);
    assign item_ready = (occupancy < (QCOUNT_W + 1)'(QUEUE_DEPTH));

    assign accept     = item_valid && item_ready;
    assign is_pix     = (item.kind == KIND_PIXEL);
    assign take_pix   = accept && is_pix && !flushing_reg;
    assign take_flush = accept && !is_pix && flushing_reg;
    assign take_any   = take_pix || take_flush;
    assign restart    = cfg_write
                     && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

    // effective dimensions and positions
    always_comb
    begin
        w_eff = clamp_dim(width_reg, WIDTH_CAP);
        h_eff = clamp_dim(height_reg, HEIGHT_CAP);
        c_eff = (col_reg == '0 || col_reg > w_eff) ? w_eff : col_reg;
        r_eff = (row_reg == '0 || row_reg > h_eff) ? h_eff : row_reg;
        p_eff = (pend_reg == '0 || pend_reg > w_eff) ? w_eff : pend_reg;
        raddr = is_pix ? AW'(c_eff - DIM_W'(1)) : AW'(p_eff);
        hit   = f1_valid_reg && (f1_job_reg.kind == KIND_PIXEL) && (f1_addr_reg == raddr);
    end

    // configuration writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write && cfg_index == CFG_FRAME_WIDTH)
            width_next = cfg_data;
        if (cfg_write && cfg_index == CFG_FRAME_HEIGHT)
            height_next = cfg_data;
    end

    // raster position update
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        pend_next     = pend_reg;
        flushing_next = flushing_reg;
        if (restart)
        begin
            row_next      = DIM_W'(1);
            col_next      = DIM_W'(1);
            pend_next     = DIM_W'(1);
            flushing_next = 1'b0;
        end
        else if (take_pix)
        begin
            if (c_eff == w_eff)
            begin
                col_next = DIM_W'(1);
                if (r_eff == h_eff)
                begin
                    flushing_next = 1'b1;
                    pend_next     = DIM_W'(1);
                end
                else
                begin
                    row_next = r_eff + DIM_W'(1);
                end
            end
            else
            begin
                col_next = c_eff + DIM_W'(1);
                row_next = r_eff;
            end
        end
        else if (take_flush)
        begin
            if (p_eff == w_eff)
            begin
                row_next      = DIM_W'(1);
                col_next      = DIM_W'(1);
                pend_next     = DIM_W'(1);
                flushing_next = 1'b0;
            end
            else
            begin
                pend_next = p_eff + DIM_W'(1);
            end
        end
    end

    // job classification
    always_comb
    begin
        f1_valid_next   = take_any;
        f1_job_next     = '0;
        f1_use_up_next  = 1'b0;
        f1_use_mid_next = 1'b0;
        if (is_pix)
        begin
            f1_job_next.kind      = KIND_PIXEL;
            f1_job_next.row       = r_eff;
            f1_job_next.col       = c_eff;
            f1_job_next.col_first = (c_eff == DIM_W'(1));
            f1_job_next.col_last  = (c_eff == w_eff);
            f1_job_next.row_ge2   = (r_eff >= DIM_W'(2));
            f1_job_next.seed      = (r_eff == h_eff) && (c_eff == DIM_W'(1));
            f1_job_next.data.low  = item.pixel_value;
            f1_use_up_next        = (r_eff >= DIM_W'(3));
            f1_use_mid_next       = (r_eff >= DIM_W'(2));
        end
        else
        begin
            f1_job_next.kind = KIND_FLUSH;
            f1_job_next.row  = h_eff;
            f1_job_next.col  = p_eff;
            f1_job_next.done = (p_eff == w_eff);
            f1_use_up_next   = (p_eff < w_eff) && (h_eff >= DIM_W'(2));
            f1_use_mid_next  = (p_eff < w_eff);
        end
    end

    // line store read data with bypass of the write that was pending when the read was issued
    always_comb
    begin
        eff_word     = f1_hit_reg ? wr_word_reg : rd_word_reg;
        wr_word.up   = eff_word.mid;
        wr_word.mid  = f1_job_reg.data.low;
        f1_write     = f1_valid_reg && (f1_job_reg.kind == KIND_PIXEL);
        push         = f1_valid_reg;
        push_job     = f1_job_reg;
        push_job.data.up  = f1_use_up_reg ? eff_word.up : '0;
        push_job.data.mid = f1_use_mid_reg ? eff_word.mid : '0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= DIM_RESET;
            height_reg   <= DIM_RESET;
            row_reg      <= DIM_W'(1);
            col_reg      <= DIM_W'(1);
            pend_reg     <= DIM_W'(1);
            flushing_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            pend_reg     <= pend_next;
            flushing_reg <= flushing_next;
            f1_valid_reg <= f1_valid_next;
        end
    end

    // issue stage payload
    always_ff @(posedge clk)
    begin
        if (take_any)
        begin
            f1_job_reg     <= f1_job_next;
            f1_addr_reg    <= raddr;
            f1_hit_reg     <= hit;
            f1_use_up_reg  <= f1_use_up_next;
            f1_use_mid_reg <= f1_use_mid_next;
        end
    end

    // line store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (f1_write)
        begin
            line_mem[f1_addr_reg] <= wr_word;
            wr_word_reg           <= wr_word;
        end
        if (take_any)
            rd_word_reg <= line_mem[raddr];
    end

endmodule

// ===== rtl/core/slm_queue.sv =====
// ----------------------------------------------------------------------------
// slm_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module slm_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  slm_pkg::job_t                push_job,
    input  logic                         pop,
    output logic                         head_valid,
    output slm_pkg::job_t                head_job,
    output logic [slm_pkg::QCOUNT_W-1:0] count
);
    import slm_pkg::*;

    job_t slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0] count_reg, count_next;
    logic do_pop;

    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        if (push && !do_pop)
            count_next = count_reg + QCOUNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - QCOUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/core/slm_back.sv =====
// ----------------------------------------------------------------------------
// slm_back
// keeps the 3x3 window, decides peaks, counts them and drives the
// result register
// ----------------------------------------------------------------------------
module slm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  slm_pkg::job_t    head_job,
    output logic             pop,
    input  logic             restart,
    output logic             result_valid,
    input  logic             result_ready,
    output slm_pkg::result_t result
);
    import slm_pkg::*;

    win_t win_reg, win_next;
    col_t fprev_reg, fprev_next;
    col_t fcur_reg, fcur_next;
    logic phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    win_t win_new, win_b, win_f, base, sel_win;
    dim_t sel_row, sel_col;
    logic sel_done, sel_eor;
    logic is_pix, first_dec, second, hold_second, emit, fire, can_out, pk;
    logic [COUNT_W-1:0] total;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign can_out      = !result_valid_reg || result_ready;

    // candidate windows
    always_comb
    begin
        win_new[0] = head_job.col_first ? col_t'('0) : win_reg[1];
        win_new[1] = head_job.col_first ? col_t'('0) : win_reg[2];
        win_new[2] = head_job.data;
        base       = phase_reg ? win_reg : win_new;
        win_b[0]   = base[1];
        win_b[1]   = base[2];
        win_b[2]   = '0;
        win_f[0]   = fprev_reg;
        win_f[1]   = fcur_reg;
        win_f[2]   = head_job.data;
    end

    // decision select
    always_comb
    begin
        is_pix      = (head_job.kind == KIND_PIXEL);
        first_dec   = head_job.row_ge2 && !head_job.col_first;
        second      = head_job.row_ge2 && head_job.col_last;
        hold_second = is_pix && !phase_reg && first_dec && second;
        emit        = 1'b0;
        sel_win     = win_new;
        sel_row     = head_job.row - DIM_W'(1);
        sel_col     = head_job.col - DIM_W'(1);
        sel_done    = 1'b0;
        sel_eor     = 1'b1;
        if (!is_pix)
        begin
            emit     = 1'b1;
            sel_win  = win_f;
            sel_row  = head_job.row;
            sel_col  = head_job.col;
            sel_done = head_job.done;
        end
        else if (phase_reg)
        begin
            emit    = 1'b1;
            sel_win = win_b;
            sel_col = head_job.col;
        end
        else if (first_dec)
        begin
            emit    = 1'b1;
            sel_eor = !second;
        end
        else if (second)
        begin
            emit    = 1'b1;
            sel_win = win_b;
            sel_col = head_job.col;
        end
        fire  = head_valid && (!emit || can_out);
        pop   = fire && !hold_second;
        pk    = slm_is_peak(sel_win);
        total = (pk && count_reg != COUNT_MAX) ? count_reg + COUNT_W'(1) : count_reg;
    end

    // window, flush columns, phase and peak count
    always_comb
    begin
        win_next   = win_reg;
        fprev_next = fprev_reg;
        fcur_next  = fcur_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        if (restart)
        begin
            win_next   = '0;
            phase_next = 1'b0;
            count_next = '0;
        end
        else if (fire)
        begin
            phase_next = hold_second;
            if (is_pix && !phase_reg)
            begin
                win_next = win_new;
                if (head_job.seed)
                begin
                    fprev_next     = '0;
                    fcur_next.up   = head_job.data.mid;
                    fcur_next.mid  = head_job.data.low;
                    fcur_next.low  = '0;
                end
            end
            if (!is_pix)
            begin
                fprev_next = fcur_reg;
                fcur_next  = head_job.data;
            end
            if (emit)
                count_next = (!is_pix && head_job.done) ? '0 : total;
        end
    end

    // result register
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (fire && emit)
        begin
            result_valid_next      = 1'b1;
            result_next.row_index  = sel_row;
            result_next.col_index  = sel_col;
            result_next.is_peak    = pk;
            result_next.peak_total = total;
            result_next.frame_done = sel_done;
            result_next.end_of_run = sel_eor;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg          <= '0;
            phase_reg        <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg          <= win_next;
            phase_reg        <= phase_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fprev_reg  <= fprev_next;
        fcur_reg   <= fcur_next;
        result_reg <= result_next;
    end

endmodule

// ===== rtl/core/slm_checker.sv =====
// ----------------------------------------------------------------------------
// slm_checker
// port-level checks of the detector, bound to the top level
// ----------------------------------------------------------------------------
`include "strict_local_max_3x3_detector_top_assert.svh"

module slm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input slm_pkg::result_t result
);

    // a stalled transaction keeps its payload
    `SLM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result), "result changed while stalled")

    // the frame's last decision closes its run
    `SLM_ASSERT_SAME(a_done_ends_run, result_valid && result.frame_done,
        result.end_of_run, "frame_done without end_of_run")

    // a peak is always counted
    `SLM_ASSERT_SAME(a_peak_counted, result_valid && result.is_peak,
        result.peak_total != '0, "peak with zero total")

    // positions count from one
    `SLM_ASSERT_SAME(a_position_nonzero, result_valid,
        result.row_index != '0 && result.col_index != '0, "zero row or column")

endmodule

bind strict_local_max_3x3_detector_top slm_checker u_checker (.*);
